FILE: sv/hphh_pkg.sv
// ----------------------------------------------------------------------------
// hphh_pkg
// shared constants, codes and types for the hot pixel hit histogram
// ----------------------------------------------------------------------------
package hphh_pkg;

    localparam int COLUMNS    = 1024;
    localparam int ROWS       = 512;
    localparam int COUNT_BITS = 16;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CMP_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(CELLS - 1);

    localparam int COL_W    = 10;
    localparam int ROW_W    = 9;
    localparam int OUT_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CUT_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_CUT    = 2'd1;

    typedef enum logic
    {
        CLR_SWEEP,
        CLR_DONE
    } clr_state_t;

    typedef struct packed
    {
        logic              busy;
        logic              we;
        logic [ADDR_W-1:0] addr;
    } clr_ctrl_t;

endpackage

FILE: sv/hphh_count_ram.sv
// ----------------------------------------------------------------------------
// hphh_count_ram
// counter store, one write port and one registered read port
// ----------------------------------------------------------------------------
module hphh_count_ram
(
    input  logic                            clk,
    input  logic                            we,
    input  logic [hphh_pkg::ADDR_W-1:0]     waddr,
    input  logic [hphh_pkg::COUNT_BITS-1:0] wdata,
    input  logic                            re,
    input  logic [hphh_pkg::ADDR_W-1:0]     raddr,
    output logic [hphh_pkg::COUNT_BITS-1:0] rdata
);
    import hphh_pkg::*;

    logic [COUNT_BITS-1:0] mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/hphh_clear_seq.sv
// ----------------------------------------------------------------------------
// hphh_clear_seq
// zeroes the counter store after reset, one entry per cycle
// ----------------------------------------------------------------------------
module hphh_clear_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    output hphh_pkg::clr_ctrl_t   ctrl
);
    import hphh_pkg::*;

    clr_state_t        state_reg;
    clr_state_t        state_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CLR_SWEEP;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        case (state_reg)
            CLR_SWEEP:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = CLR_DONE;
                end
            end
            CLR_DONE:
            begin
                addr_next = addr_reg;
            end
            default:
            begin
                state_next = CLR_SWEEP;
                addr_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        ctrl.busy = 1'b0;
        ctrl.we   = 1'b0;
        ctrl.addr = addr_reg;
        case (state_reg)
            CLR_SWEEP:
            begin
                ctrl.busy = 1'b1;
                ctrl.we   = 1'b1;
            end
            CLR_DONE:
            begin
                ctrl.busy = 1'b0;
                ctrl.we   = 1'b0;
            end
            default:
            begin
                ctrl.busy = 1'b1;
                ctrl.we   = 1'b0;
            end
        endcase
    end

endmodule

FILE: sv/hphh_update.sv
// ----------------------------------------------------------------------------
// hphh_update
// saturating increment of one counter and the hot test against the cut
// ----------------------------------------------------------------------------
module hphh_update
(
    input  logic [hphh_pkg::COUNT_BITS-1:0] old_count,
    input  logic                            command,
    input  logic                            in_range,
    input  logic                            cut_enable,
    input  logic [hphh_pkg::OUT_W-1:0]      hit_cut,
    output logic [hphh_pkg::COUNT_BITS-1:0] new_count,
    output logic                            write_en,
    output logic [hphh_pkg::OUT_W-1:0]      count_out,
    output logic                            hot
);
    import hphh_pkg::*;

    logic [31:0]    count_wide;
    logic [CMP_W-1:0] count_cmp;
    logic [CMP_W-1:0] cut_cmp;

    always_comb
    begin
        write_en  = in_range && (command == CMD_RECORD) && (old_count != COUNT_MAX);
        new_count = write_en ? old_count + 1'b1 : old_count;
        count_wide = in_range ? 32'(new_count) : 32'd0;
        count_out = count_wide[OUT_W-1:0];
        count_cmp = CMP_W'(count_wide);
        cut_cmp   = CMP_W'(hit_cut);
        hot       = in_range && cut_enable && (count_cmp > cut_cmp);
    end

endmodule

FILE: sv/hot_pixel_hit_histogram.sv
// result: each taken word passes the s1 register and then the output register
// throughput: one word per cycle when not stalled; a record and a query to
//   the same pixel may follow back to back, the updated count is forwarded
//   around the store; reset: the store is swept to zero, one entry per cycle,
//   while input is stalled; configuration writes are taken
// ----------------------------------------------------------------------------
// hot_pixel_hit_histogram
// per-pixel saturating hit counters with a hot flag against a programmable cut
// ----------------------------------------------------------------------------
module hot_pixel_hit_histogram
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic [hphh_pkg::COL_W-1:0]       pixel_column,
    input  logic [hphh_pkg::ROW_W-1:0]       pixel_row,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [hphh_pkg::OUT_W-1:0]       hit_count,
    output logic                             is_hot,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hphh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hphh_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hphh_pkg::*;

    clr_ctrl_t clr;

    logic              in_accept;
    logic              in_range;
    logic [ADDR_W-1:0] in_addr;
    logic [31:0]       addr_wide;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_cmd_reg;
    logic              s1_cmd_next;
    logic              s1_range_reg;
    logic              s1_range_next;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [ADDR_W-1:0] s1_addr_next;
    logic              s1_adv;

    logic                  fwd_hit_reg;
    logic                  fwd_hit_next;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [COUNT_BITS-1:0] fwd_data_next;

    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] old_count;
    logic [COUNT_BITS-1:0] new_count;
    logic                  upd_we;
    logic [OUT_W-1:0]      upd_count;
    logic                  upd_hot;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_W-1:0]  hit_count_reg;
    logic [OUT_W-1:0]  hit_count_next;
    logic              is_hot_reg;
    logic              is_hot_next;

    logic              cut_enable_reg;
    logic              cut_enable_next;
    logic [OUT_W-1:0]  hit_cut_reg;
    logic [OUT_W-1:0]  hit_cut_next;

    hphh_clear_seq u_clear
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (clr)
    );

    hphh_count_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (in_addr),
        .rdata (rd_data)
    );

    hphh_update u_update
    (
        .old_count  (old_count),
        .command    (s1_cmd_reg),
        .in_range   (s1_range_reg),
        .cut_enable (cut_enable_reg),
        .hit_cut    (hit_cut_reg),
        .new_count  (new_count),
        .write_en   (upd_we),
        .count_out  (upd_count),
        .hot        (upd_hot)
    );

    // input side and address
    always_comb
    begin
        s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
        in_stall  = clr.busy || (s1_valid_reg && !s1_adv);
        in_accept = in_valid && !in_stall;
        in_range  = (32'(pixel_column) < 32'(COLUMNS)) && (32'(pixel_row) < 32'(ROWS));
        addr_wide = 32'(pixel_row) * 32'(COLUMNS) + 32'(pixel_column);
        in_addr   = in_range ? addr_wide[ADDR_W-1:0] : '0;
    end

    // write port shared between the clear sweep and counter updates
    always_comb
    begin
        if (clr.busy)
        begin
            ram_we    = clr.we;
            ram_waddr = clr.addr;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_adv && upd_we;
            ram_waddr = s1_addr_reg;
            ram_wdata = new_count;
        end
    end

    // read data bypass when the previous word addressed the same entry
    always_comb
    begin
        old_count = fwd_hit_reg ? fwd_data_reg : rd_data;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_cmd_next   = s1_cmd_reg;
        s1_range_next = s1_range_reg;
        s1_addr_next  = s1_addr_reg;
        fwd_hit_next  = fwd_hit_reg;
        fwd_data_next = fwd_data_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
            s1_cmd_next   = command;
            s1_range_next = in_range;
            s1_addr_next  = in_addr;
            fwd_hit_next  = s1_adv && s1_range_reg && (s1_addr_reg == in_addr);
            fwd_data_next = new_count;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        hit_count_next = hit_count_reg;
        is_hot_next    = is_hot_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
            hit_count_next = upd_count;
            is_hot_next    = upd_hot;
        end
    end

    always_comb
    begin
        cfg_ready       = 1'b1;
        cut_enable_next = cut_enable_reg;
        hit_cut_next    = hit_cut_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CUT_ENABLE: cut_enable_next = cfg_data[0];
                REG_HIT_CUT:    hit_cut_next    = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            cut_enable_reg <= 1'b0;
            hit_cut_reg    <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            fwd_hit_reg    <= fwd_hit_next;
            out_valid_reg  <= out_valid_next;
            cut_enable_reg <= cut_enable_next;
            hit_cut_reg    <= hit_cut_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg    <= s1_cmd_next;
        s1_range_reg  <= s1_range_next;
        s1_addr_reg   <= s1_addr_next;
        fwd_data_reg  <= fwd_data_next;
        hit_count_reg <= hit_count_next;
        is_hot_reg    <= is_hot_next;
    end

    assign out_valid = out_valid_reg;
    assign hit_count = hit_count_reg;
    assign is_hot    = is_hot_reg;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hot pixel hit histogram. A scoreboard class
// keeps its own copy of the per-pixel counters and the cut settings. It
// predicts hit_count and is_hot for every accepted word and checks each
// result word in order. Stimulus covers corner pixels, back to back
// record/query on one pixel, repeated records on one pixel around the cut,
// several cut settings and weighted random traffic. Random gaps fall on both
// channels, and one long output hold fills the pipe.
// ----------------------------------------------------------------------------
module tb;
    import hphh_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int SAT_COLUMN    = 700;
    localparam int SAT_ROW       = 300;
    localparam int SAT_RECORDS   = 6;
    localparam int RANDOM_WORDS  = 520;
    localparam int SEGMENTS      = 5;
    localparam int PRESSURE_HOLD = 150;
    localparam int QUIET_LIMIT   = 4 * CELLS + 20000;
    localparam int MAX_PRINTED   = 40;

    typedef struct packed
    {
        logic [OUT_W-1:0] count;
        logic             hot;
    } hit_word_t;

    class hit_scoreboard;
        logic [COUNT_BITS-1:0] counts [int unsigned];
        logic                  cut_on;
        logic [CFG_DATA_W-1:0] cut;
        hit_word_t             due_words [$];
        string                 faults [$];

        function new();
            cut_on = 1'b0;
            cut    = '0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_CUT_ENABLE)
                cut_on = data[0];
            else if (index == REG_HIT_CUT)
                cut = data;
        endfunction

        function void note_word(logic cmd, logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
            hit_word_t             w;
            int unsigned           addr;
            logic [COUNT_BITS-1:0] n;
            w.count = '0;
            w.hot   = 1'b0;
            if (int'(col) < COLUMNS && int'(row) < ROWS)
            begin
                addr = int'(row) * COLUMNS + int'(col);
                n    = counts.exists(addr) ? counts[addr] : '0;
                if (cmd == CMD_RECORD && n != COUNT_MAX)
                begin
                    n            = n + 1'b1;
                    counts[addr] = n;
                end
                w.count = OUT_W'(n);
                w.hot   = cut_on && (CMP_W'(n) > CMP_W'(cut));
            end
            due_words = {due_words, w};
        endfunction

        function void check_word(logic [OUT_W-1:0] count, logic hot);
            hit_word_t w;
            if (due_words.size() == 0)
            begin
                faults = {faults, $sformatf("unexpected result word: hit_count %0d is_hot %0b",
                                            count, hot)};
                return;
            end
            w = due_words.pop_front();
            if (count !== w.count)
                faults = {faults, $sformatf("hit_count %0d, expected %0d", count, w.count)};
            if (hot !== w.hot)
                faults = {faults, $sformatf("is_hot %0b, expected %0b (count %0d)",
                                            hot, w.hot, w.count)};
        endfunction

        function int pending();
            return due_words.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  command;
    logic [COL_W-1:0]      pixel_column;
    logic [ROW_W-1:0]      pixel_row;
    logic                  out_valid;
    logic                  out_stall;
    logic [OUT_W-1:0]      hit_count;
    logic                  is_hot;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hit_scoreboard sb;
    int            errors       = 0;
    int            quiet_cycles = 0;
    int            pressure_req = 0;
    int            pressure_ack = 0;
    bit            steady_in    = 1'b0;
    bit            steady_out   = 1'b0;

    hot_pixel_hit_histogram dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit_count    (hit_count),
        .is_hot       (is_hot),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic report(input string what);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic send_word(input logic cmd, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        pixel_column <= col;
        pixel_row    <= row;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_cut(input logic enable, input logic [CFG_DATA_W-1:0] cut);
        write_register(REG_CUT_ENABLE, CFG_DATA_W'(enable));
        write_register(REG_HIT_CUT, cut);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // scoreboard taps and watchdog
    always @(posedge clk)
    begin
        logic took_cfg;
        logic took_in;
        logic took_out;
        took_cfg = rst_n && cfg_valid && cfg_ready;
        took_in  = rst_n && in_valid && !in_stall;
        took_out = rst_n && out_valid && !out_stall;
        if (took_cfg)
            sb.write_register(cfg_index, cfg_data);
        if (took_out)
        begin
            sb.check_word(hit_count, is_hot);
            while (sb.faults.size() > 0)
                report(sb.faults.pop_front());
        end
        if (took_in)
            sb.note_word(command, pixel_column, pixel_row);
        if (took_cfg || took_in || took_out)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side stalls
    initial
    begin
        logic hold;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (pressure_req != pressure_ack)
            begin
                pressure_ack = pressure_req;
                out_stall <= 1'b1;
                repeat (PRESSURE_HOLD) @(posedge clk);
            end
            else if (steady_out)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                hold = ($urandom_range(0, 3) == 0);
                out_stall <= hold;
                repeat (hold ? idle_length() + 1 : $urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int               seg;
        int               n;
        int               pick;
        int               slot;
        logic             cmd;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] pool_col [8];
        logic [ROW_W-1:0] pool_row [8];

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= CMD_RECORD;
        pixel_column <= '0;
        pixel_row    <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_CUT_ENABLE;
        cfg_data     <= '0;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // writes to indexes past the register list must be ignored
        write_register(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 65535)));
        write_register(REG_SPARE_HI, '1);
        program_cut(1'b1, '0);

        // corner pixels and back to back traffic on one pixel
        send_word(CMD_QUERY,  '0, '0, 0);
        send_word(CMD_RECORD, '0, '0, idle_length());
        send_word(CMD_RECORD, '0, '0, 0);
        send_word(CMD_QUERY,  '0, '0, 0);
        send_word(CMD_RECORD, '0, '0, 0);
        send_word(CMD_RECORD, '1, '1, idle_length());
        send_word(CMD_QUERY,  '1, '1, 0);
        send_word(CMD_RECORD, '1, '0, idle_length());
        send_word(CMD_RECORD, '0, '1, 0);
        send_word(CMD_RECORD, 10'h2AA, 9'h155, idle_length());
        send_word(CMD_RECORD, 10'h155, 9'h0AA, 0);
        send_word(CMD_QUERY,  10'h2AA, 9'h155, 0);
        send_word(CMD_RECORD, 10'd512, 9'd256, idle_length());
        drain();

        // cut disabled: nothing is hot whatever the count
        program_cut(1'b0, CFG_DATA_W'(1));
        send_word(CMD_QUERY,  '0, '0, 0);
        send_word(CMD_RECORD, '0, '0, idle_length());
        send_word(CMD_QUERY,  '1, '1, 0);
        drain();

        program_cut(1'b1, CFG_DATA_W'(3));
        send_word(CMD_QUERY,  '0, '0, 0);
        send_word(CMD_RECORD, 10'h2AA, 9'h155, 0);
        send_word(CMD_QUERY,  10'h155, 9'h0AA, idle_length());
        drain();

        // repeated records on one pixel, cut just below and then at the count
        program_cut(1'b1, CFG_DATA_W'(SAT_RECORDS - 1));
        steady_in  = 1'b1;
        steady_out = 1'b1;
        repeat (SAT_RECORDS)
            send_word(CMD_RECORD, COL_W'(SAT_COLUMN), ROW_W'(SAT_ROW), 0);
        send_word(CMD_QUERY, COL_W'(SAT_COLUMN), ROW_W'(SAT_ROW), 0);
        drain();
        program_cut(1'b1, CFG_DATA_W'(SAT_RECORDS));
        send_word(CMD_QUERY, COL_W'(SAT_COLUMN), ROW_W'(SAT_ROW), 0);
        send_word(CMD_RECORD, COL_W'(SAT_COLUMN), ROW_W'(SAT_ROW), 0);

        // random traffic, mostly on a few busy pixels
        pool_col[0] = COL_W'(SAT_COLUMN);
        pool_row[0] = ROW_W'(SAT_ROW);
        for (slot = 1; slot < 8; slot++)
        begin
            pool_col[slot] = COL_W'($urandom);
            pool_row[slot] = ROW_W'($urandom);
        end

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            case (seg)
                0:       program_cut(1'b1, '0);
                1:       program_cut(1'b1, CFG_DATA_W'(2));
                2:       program_cut(1'b0, CFG_DATA_W'($urandom_range(0, 65535)));
                3:       program_cut(1'b1, '1);
                default: program_cut(1'b1, CFG_DATA_W'($urandom_range(1, 6)));
            endcase
            for (n = 0; n < RANDOM_WORDS / SEGMENTS; n++)
            begin
                if (n % 25 == 0)
                begin
                    steady_in  = ($urandom_range(0, 3) == 0);
                    steady_out = ($urandom_range(0, 3) == 0);
                end
                // long output hold while input keeps coming
                if (seg == 1 && n == 30)
                begin
                    pressure_req++;
                    steady_in = 1'b1;
                end
                cmd  = ($urandom_range(0, 9) < 7) ? CMD_RECORD : CMD_QUERY;
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    slot = $urandom_range(0, 7);
                    col  = pool_col[slot];
                    row  = pool_row[slot];
                end
                else if (pick < 62)
                begin
                    col = $urandom_range(0, 1) ? '1 : '0;
                    row = $urandom_range(0, 1) ? '1 : '0;
                end
                else
                begin
                    col = COL_W'($urandom);
                    row = ROW_W'($urandom);
                end
                send_word(cmd, col, row, steady_in ? 0 : idle_length());
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
